// File: sv/psm_pkg.sv
// Shared types and constants for the plate stack with running minimum.
package psm_pkg;

    // Operation codes carried in the func field
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_UNDERFLOW = 2'd1;
    localparam status_t STATUS_OVERFLOW  = 2'd2;

    // Plate capacity limits and reset value
    localparam int unsigned CAP_W = 9;
    localparam logic [CAP_W-1:0] CAP_MIN   = 9'd1;
    localparam logic [CAP_W-1:0] CAP_MAX   = 9'd256;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd10;

    // Controller to datapath commands
    typedef struct packed {
        logic exec_now;      // complete the accepted item in its accept cycle
        logic start_fetch;   // pop that needs the entry below the top
        logic finish_fetch;  // memory data is back, finish the pop
    } psm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic last;          // exactly one entry held
    } psm_sts_t;

endpackage

// File: sv/psm_if.sv
// Valid/ready channel interfaces for requests and responses.
interface psm_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface psm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] popped_value;
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic signed [31:0] plate_min;
    logic [7:0]         plate_number;
    logic [8:0]         plate_fill;
    logic               stack_empty;

    modport source (output valid, output popped_value, output status, output top_value,
                    output plate_min, output plate_number, output plate_fill,
                    output stack_empty, input ready);
    modport sink   (input valid, input popped_value, input status, input top_value,
                    input plate_min, input plate_number, input plate_fill,
                    input stack_empty, output ready);
endinterface

// File: sv/psm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/psm_dp.sv
// Datapath: counters, cached top entry, entry memory and response registers.
module psm_dp #(
    parameter int TOTAL_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  psm_pkg::psm_cmd_t  cmd,
    output psm_pkg::psm_sts_t  sts,
    input  logic               cfg_we,
    input  logic [8:0]         cfg_data,
    input  logic               func,
    input  logic signed [31:0] push_value,
    output logic signed [31:0] popped_value,
    output logic [1:0]         status,
    output logic signed [31:0] top_value,
    output logic signed [31:0] plate_min,
    output logic [7:0]         plate_number,
    output logic [8:0]         plate_fill,
    output logic               stack_empty
);

    import psm_pkg::*;

    localparam int CW = $clog2(TOTAL_DEPTH + 1);
    localparam int AW = $clog2(TOTAL_DEPTH);

    // state
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [7:0]         index_reg, index_next;
    logic [8:0]         fill_reg, fill_next;
    logic signed [31:0] top_reg, top_next;
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] hold_reg, hold_next;

    // response payload
    logic signed [31:0] rsp_popped_reg, rsp_popped_next;
    status_t            rsp_status_reg, rsp_status_next;
    logic               rsp_load;

    // memory ports
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [63:0]        ram_wdata;
    logic [63:0]        ram_rdata;

    logic               is_empty;
    logic               is_full;
    logic               new_plate;
    logic signed [31:0] push_min;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(TOTAL_DEPTH));

    assign sts.empty = is_empty;
    assign sts.last  = (count_reg == CW'(1));

    // running minimum of the plate including the pushed value
    assign new_plate = is_empty || (fill_reg >= cap_reg);
    assign push_min  = (new_plate || (push_value < min_reg)) ? push_value : min_reg;

    // entry memory: value in the upper half, running minimum in the lower half
    assign ram_we    = cmd.exec_now && (func == FUNC_PUSH) && !is_full;
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = {push_value, push_min};
    assign ram_raddr = AW'(count_reg - CW'(2));

    psm_ram #(
        .WIDTH (64),
        .DEPTH (TOTAL_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.start_fetch),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next-state logic for the stack and the response
    always_comb
    begin
        cap_next        = cap_reg;
        count_next      = count_reg;
        index_next      = index_reg;
        fill_next       = fill_reg;
        top_next        = top_reg;
        min_next        = min_reg;
        hold_next       = hold_reg;
        rsp_popped_next = 32'sd0;
        rsp_status_next = STATUS_OK;
        rsp_load        = 1'b0;

        // capacity only changes while nothing is stored
        if (cfg_we && is_empty)
        begin
            if (cfg_data == '0)
            begin
                cap_next = CAP_MIN;
            end
            else if (cfg_data > CAP_MAX)
            begin
                cap_next = CAP_MAX;
            end
            else
            begin
                cap_next = cfg_data;
            end
        end

        if (cmd.exec_now)
        begin
            rsp_load = 1'b1;
            if (func == FUNC_PUSH)
            begin
                if (is_full)
                begin
                    rsp_status_next = STATUS_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    if (is_empty)
                    begin
                        index_next = 8'd0;
                        fill_next  = 9'd1;
                    end
                    else if (fill_reg >= cap_reg)
                    begin
                        index_next = index_reg + 8'd1;
                        fill_next  = 9'd1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 9'd1;
                    end
                    top_next = push_value;
                    min_next = push_min;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    rsp_status_next = STATUS_UNDERFLOW;
                end
                else
                begin
                    // last entry leaves the stack
                    rsp_popped_next = top_reg;
                    count_next      = '0;
                    index_next      = 8'd0;
                    fill_next       = 9'd0;
                    top_next        = 32'sd0;
                    min_next        = 32'sd0;
                end
            end
        end

        // pop with entries remaining: counters move now, new top comes next cycle
        if (cmd.start_fetch)
        begin
            hold_next  = top_reg;
            count_next = count_reg - CW'(1);
            if (fill_reg <= 9'd1)
            begin
                index_next = index_reg - 8'd1;
                fill_next  = cap_reg;
            end
            else
            begin
                fill_next = fill_reg - 9'd1;
            end
        end

        if (cmd.finish_fetch)
        begin
            rsp_load        = 1'b1;
            rsp_popped_next = hold_reg;
            top_next        = ram_rdata[63:32];
            min_next        = ram_rdata[31:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            index_reg <= 8'd0;
            fill_reg  <= 9'd0;
            top_reg   <= 32'sd0;
            min_reg   <= 32'sd0;
        end
        else
        begin
            cap_reg   <= cap_next;
            count_reg <= count_next;
            index_reg <= index_next;
            fill_reg  <= fill_next;
            top_reg   <= top_next;
            min_reg   <= min_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (rsp_load)
        begin
            rsp_popped_reg <= rsp_popped_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

    // response fields; stack fields hold steady until the next item completes
    assign popped_value = rsp_popped_reg;
    assign status       = rsp_status_reg;
    assign top_value    = top_reg;
    assign plate_min    = min_reg;
    assign plate_number = index_reg;
    assign plate_fill   = fill_reg;
    assign stack_empty  = is_empty;

    // an empty stack reports plate 0 with no fill
    a_empty_plate: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (fill_reg == 9'd0 && index_reg == 8'd0))
        else $error("empty stack with nonzero plate state");

    // a non-empty stack has its top plate partly or fully filled
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (fill_reg != 9'd0 && fill_reg <= cap_reg))
        else $error("plate fill out of range");

    // entry count never passes the memory depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TOTAL_DEPTH))
        else $error("entry count beyond depth");

endmodule

// File: sv/psm_ctrl.sv
// Controller: request acceptance, pop sequencing and response valid.
module psm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_func,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output psm_pkg::psm_cmd_t cmd,
    input  psm_pkg::psm_sts_t sts
);

    import psm_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   req_fire;

    // take a new item while idle, once the response slot is free or drains this cycle
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        cmd.exec_now     = 1'b0;
        cmd.start_fetch  = 1'b0;
        cmd.finish_fetch = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req_func == FUNC_POP && !sts.empty && !sts.last)
                    begin
                        cmd.start_fetch = 1'b1;
                        state_next      = S_FETCH;
                    end
                    else
                    begin
                        cmd.exec_now   = 1'b1;
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.finish_fetch = 1'b1;
                rsp_valid_next   = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // the response slot is free while the memory read is outstanding
    a_fetch_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !rsp_valid_reg)
        else $error("fetch with response slot occupied");

    // the fetch state returns to idle with the response valid
    a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |=> (state_reg == S_IDLE && rsp_valid_reg))
        else $error("fetch did not complete");

    // a fetch is only started for a pop that leaves entries behind
    a_fetch_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_fetch |-> (!sts.empty && !sts.last))
        else $error("fetch started without a lower entry");

endmodule

// File: sv/plate_stack_with_min_core.sv
// Top level of the plate stack with per-plate running minimum.
//
// Usage:
//   req carries one push (func 0, push_value) or pop (func 1) per transfer.
//   rsp returns exactly one result per request, in order: popped value,
//   status, new top value, plate minimum, plate number, plate fill, empty.
//   cfg_we/cfg_data set the plate capacity; the write only takes effect
//   while the stack is empty, 0 is taken as 1 and values above 256 as 256.
// Sequencing:
//   A push, an error or a pop of the last entry finishes in the accept cycle
//   and shows on rsp the next cycle: one item per cycle while rsp is ready. A
//   pop that leaves entries reads the new top from the entry memory (registered
//   read port) in a fetch state, and the next request is taken after it.
// Reset:
//   Clears the stack to empty, capacity 10; memory contents are not cleared
//   and are never read before being written.
// Stall:
//   A finished result waits in the response register; req stays ready while
//   that register drains the same cycle, otherwise req is held off.
module plate_stack_with_min_core #(
    parameter int TOTAL_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    psm_req_if.sink    req,
    psm_rsp_if.source  rsp,
    input  logic       cfg_we,
    input  logic [8:0] cfg_data
);

    import psm_pkg::*;

    psm_cmd_t cmd;
    psm_sts_t sts;

    // sequencing
    psm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // stack storage and result fields
    psm_dp #(
        .TOTAL_DEPTH (TOTAL_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .func         (req.func),
        .push_value   (req.push_value),
        .popped_value (rsp.popped_value),
        .status       (rsp.status),
        .top_value    (rsp.top_value),
        .plate_min    (rsp.plate_min),
        .plate_number (rsp.plate_number),
        .plate_fill   (rsp.plate_fill),
        .stack_empty  (rsp.stack_empty)
    );

endmodule

// File: tb/tb_plate_stack_with_min_core.sv
// Testbench for plate_stack_with_min_core: directed and random push/pop traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_plate_stack_with_min_core;
    import psm_pkg::*;

    localparam int unsigned STACK_DEPTH = 256;
    localparam int unsigned IDLE_PCT    = 6;
    localparam int unsigned STALL_LIMIT = 2000;

    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    // One request as queued for the driver
    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
    } stack_op_t;

    // One predicted response
    typedef struct packed {
        logic signed [31:0] popped;
        status_t            status;
        logic signed [31:0] top;
        logic signed [31:0] min;
        logic [7:0]         plate;
        logic [8:0]         fill;
        logic               empty;
    } stack_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we = 1'b0;
    logic [8:0] cfg_data = '0;

    psm_req_if req_ch ();
    psm_rsp_if rsp_ch ();

    plate_stack_with_min_core #(
        .TOTAL_DEPTH (STACK_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic signed [31:0] plate_vals [STACK_DEPTH];
    logic signed [31:0] plate_mins [STACK_DEPTH];
    int unsigned        stack_depth = 0;
    int unsigned        cur_plate = 0;
    int unsigned        cur_fill = 0;
    logic signed [31:0] cur_top = '0;
    logic signed [31:0] cur_min = '0;
    logic [8:0]         capacity = CAP_RESET;

    // Test bookkeeping
    stack_op_t     pending_ops [$];
    stack_result_t awaited_results [$];
    int unsigned   gen_depth = 0;
    int unsigned   err_count = 0;
    int unsigned   stall_cycles = 0;
    logic          timed_out = 1'b0;
    logic          gaps_on = 1'b1;

    // Capacity write: only honored when empty, clamped to 1..256
    function automatic void set_capacity(input logic [8:0] v);
        logic [8:0] c;
        c = v;
        if (stack_depth != 0)
            return;
        if (c < CAP_MIN)
            c = CAP_MIN;
        if (c > CAP_MAX)
            c = CAP_MAX;
        capacity = c;
    endfunction

    // Apply one push or pop to the predicted stack and return the response
    function automatic stack_result_t apply_stack_op(input logic op,
                                                     input logic signed [31:0] v);
        stack_result_t      r;
        logic signed [31:0] m;
        r.popped = '0;
        r.status = STATUS_OK;
        if (op == FUNC_PUSH)
        begin
            if (stack_depth >= STACK_DEPTH)
                r.status = STATUS_OVERFLOW;
            else
            begin
                if (stack_depth == 0)
                begin
                    cur_plate = 0;
                    cur_fill  = 1;
                    m = v;
                end
                else if (cur_fill >= capacity)
                begin
                    cur_plate = cur_plate + 1;
                    cur_fill  = 1;
                    m = v;
                end
                else
                begin
                    cur_fill = cur_fill + 1;
                    m = (v < cur_min) ? v : cur_min;
                end
                plate_vals[stack_depth] = v;
                plate_mins[stack_depth] = m;
                stack_depth = stack_depth + 1;
                cur_top = v;
                cur_min = m;
            end
        end
        else
        begin
            if (stack_depth == 0)
                r.status = STATUS_UNDERFLOW;
            else
            begin
                r.popped = cur_top;
                stack_depth = stack_depth - 1;
                if (stack_depth == 0)
                begin
                    cur_plate = 0;
                    cur_fill  = 0;
                    cur_top   = '0;
                    cur_min   = '0;
                end
                else
                begin
                    // leaving a plate's last entry drops back to a full plate
                    if (cur_fill <= 1)
                    begin
                        cur_plate = cur_plate - 1;
                        cur_fill  = 32'(capacity);
                    end
                    else
                        cur_fill = cur_fill - 1;
                    cur_top = plate_vals[stack_depth-1];
                    cur_min = plate_mins[stack_depth-1];
                end
            end
        end
        r.top   = cur_top;
        r.min   = cur_min;
        r.plate = cur_plate[7:0];
        r.fill  = cur_fill[8:0];
        r.empty = (stack_depth == 0);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // Driver: present the next queued request after each transfer
    always @(posedge clk)
    begin : drive_req
        stack_op_t     nxt;
        stack_result_t res;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                res = apply_stack_op(req_ch.func, req_ch.push_value);
                awaited_results.insert(awaited_results.size(), res);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_ops.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT))
                begin
                    nxt = pending_ops.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.func       <= nxt.func;
                    req_ch.push_value <= nxt.value;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, compare each response transfer
    always @(posedge clk)
    begin : watch_rsp
        stack_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual top %0h",
                             $time, rsp_ch.top_value);
                    err_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("popped_value", want.popped, rsp_ch.popped_value);
                    check_field("status", 32'(want.status), 32'(rsp_ch.status));
                    check_field("top_value", want.top, rsp_ch.top_value);
                    check_field("plate_min", want.min, rsp_ch.plate_min);
                    check_field("plate_number", 32'(want.plate), 32'(rsp_ch.plate_number));
                    check_field("plate_fill", 32'(want.fill), 32'(rsp_ch.plate_fill));
                    check_field("stack_empty", 32'(want.empty), 32'(rsp_ch.stack_empty));
                end
            end
            rsp_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
        else
            rsp_ch.ready <= 1'b0;
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
                timed_out <= 1'b1;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Queue one request, tracking the depth it will leave behind
    task automatic queue_op(input logic op, input logic signed [31:0] v);
        stack_op_t o;
        o.func  = op;
        o.value = v;
        pending_ops.insert(pending_ops.size(), o);
        if (op == FUNC_PUSH && gen_depth < STACK_DEPTH)
            gen_depth++;
        else if (op == FUNC_POP && gen_depth > 0)
            gen_depth--;
    endtask

    // Mostly wide random values, with extremes and small repeats for equal minima
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0: v = INT_MIN;
                    1: v = INT_MAX;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            1, 2, 3:
            begin
                v = $urandom_range(8);
                v = v - 4;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic pick_func(input int unsigned push_pct);
        return ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
    endfunction

    task automatic random_ops(input int unsigned n, input int unsigned push_pct);
        repeat (n)
            queue_op(pick_func(push_pct), pick_value());
    endtask

    // Mostly pops until empty, then one pop too many
    task automatic drain_stack();
        while (gen_depth != 0)
            queue_op(pick_func(5), pick_value());
        queue_op(FUNC_POP, pick_value());
    endtask

    // Hold off until every request is sent and every response is back;
    // checked mid-cycle so the driver's updates have landed
    task automatic settle();
        while (pending_ops.size() != 0 || req_ch.valid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [8:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        set_capacity(v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_stimulus();
        // Directed: underflow, extremes, equal minima, plate crossing both ways
        queue_op(FUNC_POP, INT_MAX);
        queue_op(FUNC_PUSH, INT_MAX);
        queue_op(FUNC_PUSH, INT_MIN);
        queue_op(FUNC_PUSH, 32'sd0);
        queue_op(FUNC_PUSH, -32'sd1);
        queue_op(FUNC_PUSH, INT_MIN);
        queue_op(FUNC_PUSH, 32'sd5);
        queue_op(FUNC_PUSH, 32'sd5);
        queue_op(FUNC_PUSH, INT_MAX);
        queue_op(FUNC_PUSH, 32'sd1);
        queue_op(FUNC_PUSH, -32'sd2);
        queue_op(FUNC_PUSH, 32'sd3);
        repeat (11) queue_op(FUNC_POP, INT_MIN);
        queue_op(FUNC_POP, -32'sd1);
        settle();

        // Capacity 0 reads as 1: fill to full without gaps, overflow, then drain
        write_capacity(9'd0);
        gaps_on = 1'b0;
        while (gen_depth < STACK_DEPTH)
            queue_op(pick_func(95), pick_value());
        repeat (4) queue_op(FUNC_PUSH, pick_value());
        settle();
        gaps_on = 1'b1;
        drain_stack();
        settle();

        // Out-of-range capacity clamps to 256; a write with entries held is ignored
        write_capacity(9'd300);
        random_ops(100, 65);
        settle();
        write_capacity(9'd4);
        random_ops(20, 50);
        drain_stack();
        settle();

        write_capacity(9'd3);
        random_ops(80, 55);
        drain_stack();
        settle();

        write_capacity(CAP_MIN);
        random_ops(60, 55);
        drain_stack();
        settle();

        write_capacity(CAP_MAX);
        random_ops(60, 60);
        drain_stack();
        settle();

        write_capacity(9'($urandom_range(2, 40)));
        random_ops(60, 55);
        drain_stack();
        settle();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_PUSH;
        req_ch.push_value = '0;
        rsp_ch.ready      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            begin
                run_stimulus();
                repeat (8) @(posedge clk);
            end
            wait (timed_out);
        join_any

        if (!timed_out && err_count == 0)
            $display("tb_plate_stack_with_min_core: clean");
        else
            $display("tb_plate_stack_with_min_core: errors");
        $finish;
    end

endmodule

// File: plate_stack_with_min_core.f
sv/psm_pkg.sv
sv/psm_if.sv
sv/psm_ram.sv
sv/psm_dp.sv
sv/psm_ctrl.sv
sv/plate_stack_with_min_core.sv
tb/tb_plate_stack_with_min_core.sv
